>>> hw/rtl/axisymmetric_compressible_source_defines.svh
// Assertion macros shared by the checker of the axisymmetric source block.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef AXISYMMETRIC_COMPRESSIBLE_SOURCE_DEFINES_SVH
`define AXISYMMETRIC_COMPRESSIBLE_SOURCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ACS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acs check failed");

// Next-cycle implication, disabled while reset is held.
`define ACS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acs check failed");

`endif

>>> hw/rtl/acs_pkg.sv
// Types, constants and fixed-point helpers of the axisymmetric source block.
// Depends on nothing; the multiplier, divider, top level and checker import it.
package acs_pkg;

  localparam int QW = 48;
  typedef logic signed [QW-1:0] qval_t;

  localparam qval_t QMAX  = 48'sh7FFF_FFFF_FFFF;
  localparam qval_t QMIN  = 48'sh8000_0000_0000;
  localparam qval_t QONE  = 48'sh0001_0000_0000;
  localparam qval_t QHALF = 48'sh0000_8000_0000;

  localparam int GAMMA_W = 34;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 34'd6012954214;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT = 8'd1;

  localparam int EQUATION_ROWS = 4;
  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(EQUATION_ROWS - 1);

  // Pipeline depths of the arithmetic units.
  localparam int LAT_MUL   = 3;
  localparam int DIV_STEPS = 49;
  localparam int LAT_DIV   = DIV_STEPS + 2;

  typedef struct packed {
    logic [46:0] density;
    qval_t       momentum_x;
    qval_t       momentum_y;
    qval_t       total_energy;
    qval_t       radius;
    logic [46:0] cell_volume;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    qval_t            residual_value;
    qval_t            jac_col0;
    qval_t            jac_col1;
    qval_t            jac_col2;
    qval_t            jac_col3;
    logic             last_row;
  } out_word_t;

  function automatic qval_t sat49(input logic [QW:0] x);
    if (x[QW] != x[QW-1]) begin
      return x[QW] ? QMIN : QMAX;
    end
    return qval_t'(x[QW-1:0]);
  endfunction

  function automatic qval_t sat_add(input qval_t a, input qval_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    return sat49(s);
  endfunction

  function automatic qval_t sat_sub(input qval_t a, input qval_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    return sat49(s);
  endfunction

  function automatic qval_t sat_neg(input qval_t a);
    return sat_sub('0, a);
  endfunction

  function automatic logic [QW-1:0] mag48(input qval_t a);
    logic [QW-1:0] ua;
    ua = a;
    return a[QW-1] ? (~ua + 48'd1) : ua;
  endfunction

  function automatic qval_t from_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m > 64'h0000_8000_0000_0000) return QMIN;
      return qval_t'(~m[QW-1:0] + 48'd1);
    end
    if (m > 64'h0000_7FFF_FFFF_FFFF) return QMAX;
    return qval_t'(m[QW-1:0]);
  endfunction

endpackage

>>> hw/rtl/acs_qmul.sv
// Pipelined signed Q16.32 multiplier with rounding and saturation.
// Depends on acs_pkg; the pipeline advances when en_i is high.
module acs_qmul import acs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  qval_t a_i,
  input  qval_t b_i,
  output qval_t p_o
);

  logic [QW-1:0] ma_q, mb_q;
  logic          neg_a_q, neg_b_q;
  logic [31:0]   hh_q;
  logic [QW-1:0] mid1_q, mid2_q;
  logic [63:0]   ll_q;
  logic [63:0]   sum;
  qval_t         p_d, p_q;

  // Partial products are at most 32 by 32 bits; their sum is combinational and is registered in p_q.
  always_comb begin
    sum = {16'b0, hh_q[15:0], 32'b0} + {16'b0, mid1_q} + {16'b0, mid2_q}
        + {32'b0, ll_q[63:32]} + {63'b0, ll_q[31]};
    if (hh_q >= 32'h0001_0000) begin
      p_d = neg_b_q ? QMIN : QMAX;
    end else begin
      p_d = from_mag(sum, neg_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= mag48(a_i);
      mb_q    <= mag48(b_i);
      neg_a_q <= a_i[QW-1] ^ b_i[QW-1];
      hh_q    <= {16'b0, ma_q[47:32]} * {16'b0, mb_q[47:32]};
      mid1_q  <= {32'b0, ma_q[47:32]} * {16'b0, mb_q[31:0]};
      mid2_q  <= {16'b0, ma_q[31:0]} * {32'b0, mb_q[47:32]};
      ll_q    <= {32'b0, ma_q[31:0]} * {32'b0, mb_q[31:0]};
      neg_b_q <= neg_a_q;
      p_q     <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/acs_qdiv.sv
// Pipelined signed Q16.32 divider, one quotient bit per stage, with rounding.
// Depends on acs_pkg; the pipeline advances when en_i is high.
module acs_qdiv import acs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  qval_t a_i,
  input  qval_t b_i,
  output qval_t q_o
);

  logic [QW-1:0] r_q   [DIV_STEPS+1];
  logic [QW-1:0] mb_q  [DIV_STEPS+1];
  logic [15:0]   lo_q  [DIV_STEPS+1];
  logic [QW:0]   qt_q  [DIV_STEPS+1];
  logic          neg_q [DIV_STEPS+1];
  logic          ovf_q [DIV_STEPS+1];
  logic [QW-1:0] r_d   [DIV_STEPS];
  logic          bit_d [DIV_STEPS];
  logic [QW-1:0] ma, mb;
  logic [QW+1:0] rnd;
  qval_t         q_q;

  assign ma = mag48(a_i);
  assign mb = mag48(b_i);

  // Restoring steps; the dividend is the magnitude shifted up by 33 bits.
  always_comb begin
    logic [QW:0] trial;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {r_q[k], lo_q[k][15]};
      if (trial >= {1'b0, mb_q[k]}) begin
        trial    = trial - {1'b0, mb_q[k]};
        bit_d[k] = 1'b1;
      end else begin
        bit_d[k] = 1'b0;
      end
      r_d[k] = trial[QW-1:0];
    end
  end

  assign rnd = ({1'b0, qt_q[DIV_STEPS]} + 50'd1) >> 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // A zero divisor also lands in the overflow case, with the dividend's sign.
      r_q[0]   <= {16'b0, ma[47:16]};
      lo_q[0]  <= ma[15:0];
      mb_q[0]  <= mb;
      qt_q[0]  <= '0;
      neg_q[0] <= a_i[QW-1] ^ b_i[QW-1];
      ovf_q[0] <= ({16'b0, ma[47:16]} >= mb);
      for (int k = 0; k < DIV_STEPS; k++) begin
        r_q[k+1]   <= r_d[k];
        lo_q[k+1]  <= {lo_q[k][14:0], 1'b0};
        mb_q[k+1]  <= mb_q[k];
        qt_q[k+1]  <= {qt_q[k][QW-1:0], bit_d[k]};
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
      if (ovf_q[DIV_STEPS]) begin
        q_q <= neg_q[DIV_STEPS] ? QMIN : QMAX;
      end else begin
        q_q <= from_mag({14'b0, rnd}, neg_q[DIV_STEPS]);
      end
    end
  end

  assign q_o = q_q;

endmodule

>>> hw/rtl/axisymmetric_compressible_source.sv
// Axisymmetric inviscid source term of one 2D compressible cell.
// Uses cells in_word_t: a word on the input channel, four out_word_t rows out.
// The input channel takes one cell per word; the output channel gives four
// words per cell, rows 0 to 3 in order, with last_row set on row 3.
// The configuration channel is always ready; index 0 writes gamma_ratio and
// index 1 writes implicit_mode, other indexes are ignored. Write it only while
// no cell is in flight.
// The first row of a cell appears once its word has passed a chain of two
// pipelined dividers, with multiplier stages between and after them.
// Throughput: words enter every cycle while the pipeline has room; sustained,
// the rate is set by the single output channel carrying four rows per cell.
// When the receiver stalls, the whole pipeline holds in place and in_ready_o
// drops once the finished cell at its end cannot move into the output buffer.
// Reset clears all valid bits and the row counter, and loads gamma_ratio with
// about 1.4 and implicit_mode with 1.
module axisymmetric_compressible_source import acs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAMMA_W-1:0]   cfg_data_i
);

  // Stage at which each group of operations reads its operands. A unit of
  // latency L read at stage k delivers into stage k + L + 1; an add is one stage.
  localparam int S_MUL1  = LAT_DIV + 1;
  localparam int S_MUL2  = S_MUL1 + LAT_MUL + 1;
  localparam int S_MUL3  = S_MUL2 + 1;
  localparam int S_GMQ   = S_MUL3 + 1;
  localparam int S_T1    = S_MUL3 + LAT_MUL + 1;
  localparam int S_MUL4  = S_T1 + 1;
  localparam int S_P     = S_MUL4 + LAT_MUL + 1;
  localparam int S_SJ    = S_P + 1;
  localparam int S_EP    = S_P + LAT_MUL + 1;
  localparam int S_DIVH  = S_EP + 1;
  localparam int S_HMY   = S_DIVH + LAT_DIV + 1;
  localparam int S_RES3  = S_HMY + LAT_MUL + 1;
  localparam int S_LAST  = S_RES3 + LAT_MUL + 1;
  localparam int NUM_STAGES = S_LAST + 1;
  localparam int DM = LAT_MUL + 1;
  localparam int DD = LAT_DIV + 1;

  // Multiplier slots.
  localparam int M_UU = 0, M_VV = 1, M_MXV = 2, M_MYV = 3, M_UV = 4, M_VE = 5;
  localparam int M_GE = 6, M_GV = 7, M_SMY = 8, M_RES1 = 9, M_RES2 = 10;
  localparam int M_GUV = 11, M_GVE = 12, M_HQ = 13, M_VQ = 14, M_GMQ = 15;
  localparam int M_M1 = 16, M_GVQ = 17, M_HG = 18, M_P = 19;
  localparam int M_SJ10 = 20, M_SJ11 = 21, M_SJ12 = 22, M_SJ20 = 23, M_SJ22 = 24;
  localparam int M_SJ30 = 25, M_SJ31 = 26, M_SJ32 = 27, M_SJ33 = 28;
  localparam int M_HMY = 29, M_RES3 = 30;
  localparam int NUM_MUL = 31;

  // Divider slots.
  localparam int D_S = 0, D_U = 1, D_V = 2, D_E = 3, D_H = 4;
  localparam int NUM_DIV = 5;

  typedef struct packed {
    logic  axis_ok;
    qval_t rho, mx, my, egy, rad, vol;
    qval_t s, u, v, e;
    qval_t uu, vv, mxv, myv, uv, ve, ge, gv, smy;
    qval_t q, vv2, res1, res2, gm1uv, gve;
    qval_t hq, vq, qv, gmq, t1, m1, gvq, hg, p;
    qval_t j10, j20, j22, j30, j31, j32;
    qval_t sj10, sj11, sj12, sj20, sj22, sj30, sj31, sj32, sj33;
    qval_t ep, h, hmy, res3;
  } ctx_t;

  ctx_t  ctx_q [NUM_STAGES];
  ctx_t  ctx_d [NUM_STAGES];
  logic  vld_q [NUM_STAGES];
  logic  adv;
  logic  load;

  logic [GAMMA_W-1:0] gamma_q;
  logic               implicit_q;
  qval_t              g_val, gm1_val;

  qval_t mul_a [NUM_MUL];
  qval_t mul_b [NUM_MUL];
  qval_t mul_p [NUM_MUL];
  qval_t div_a [NUM_DIV];
  qval_t div_b [NUM_DIV];
  qval_t div_q [NUM_DIV];

  // Output buffer holding the four rows of one cell.
  logic             obuf_vld_q;
  logic [ROW_W-1:0] row_q;
  qval_t            res_buf_q [EQUATION_ROWS];
  qval_t            jac_buf_q [EQUATION_ROWS][EQUATION_ROWS];
  qval_t            res_row   [EQUATION_ROWS];
  qval_t            jac_row   [EQUATION_ROWS][EQUATION_ROWS];
  logic             out_acc;

  // ---------------------------------------------------------------------------
  // Configuration registers. Gamma minus one never leaves the Q16.32 range.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q    <= GAMMA_RESET;
      implicit_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAMMA:    gamma_q    <= cfg_data_i;
        REG_IMPLICIT: implicit_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign g_val   = qval_t'({14'b0, gamma_q});
  assign gm1_val = g_val - QONE;

  // ---------------------------------------------------------------------------
  // Flow control. Every stage and every unit moves together on adv.
  // ---------------------------------------------------------------------------
  assign out_acc    = out_valid_o && out_ready_i;
  assign load       = vld_q[S_LAST] && (!obuf_vld_q || (out_acc && row_q == LAST_ROW));
  assign adv        = !vld_q[S_LAST] || load;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // Arithmetic units.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < NUM_MUL; gi++) begin : g_mul
    acs_qmul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mul_a[gi]),
      .b_i   (mul_b[gi]),
      .p_o   (mul_p[gi])
    );
  end

  for (genvar gd = 0; gd < NUM_DIV; gd++) begin : g_div
    acs_qdiv u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (div_a[gd]),
      .b_i   (div_b[gd]),
      .q_o   (div_q[gd])
    );
  end

  always_comb begin
    div_a[D_S] = ctx_q[0].vol;  div_b[D_S] = ctx_q[0].rad;
    div_a[D_U] = ctx_q[0].mx;   div_b[D_U] = ctx_q[0].rho;
    div_a[D_V] = ctx_q[0].my;   div_b[D_V] = ctx_q[0].rho;
    div_a[D_E] = ctx_q[0].egy;  div_b[D_E] = ctx_q[0].rho;
    div_a[D_H] = ctx_q[S_DIVH].ep;
    div_b[D_H] = ctx_q[S_DIVH].rho;

    mul_a[M_UU]   = ctx_q[S_MUL1].u;   mul_b[M_UU]   = ctx_q[S_MUL1].u;
    mul_a[M_VV]   = ctx_q[S_MUL1].v;   mul_b[M_VV]   = ctx_q[S_MUL1].v;
    mul_a[M_MXV]  = ctx_q[S_MUL1].mx;  mul_b[M_MXV]  = ctx_q[S_MUL1].v;
    mul_a[M_MYV]  = ctx_q[S_MUL1].my;  mul_b[M_MYV]  = ctx_q[S_MUL1].v;
    mul_a[M_UV]   = ctx_q[S_MUL1].u;   mul_b[M_UV]   = ctx_q[S_MUL1].v;
    mul_a[M_VE]   = ctx_q[S_MUL1].v;   mul_b[M_VE]   = ctx_q[S_MUL1].e;
    mul_a[M_GE]   = g_val;             mul_b[M_GE]   = ctx_q[S_MUL1].e;
    mul_a[M_GV]   = g_val;             mul_b[M_GV]   = ctx_q[S_MUL1].v;
    mul_a[M_SMY]  = ctx_q[S_MUL1].s;   mul_b[M_SMY]  = ctx_q[S_MUL1].my;
    mul_a[M_RES1] = ctx_q[S_MUL2].s;   mul_b[M_RES1] = ctx_q[S_MUL2].mxv;
    mul_a[M_RES2] = ctx_q[S_MUL2].s;   mul_b[M_RES2] = ctx_q[S_MUL2].myv;
    mul_a[M_GUV]  = gm1_val;           mul_b[M_GUV]  = ctx_q[S_MUL2].uv;
    mul_a[M_GVE]  = g_val;             mul_b[M_GVE]  = ctx_q[S_MUL2].ve;
    mul_a[M_HQ]   = QHALF;             mul_b[M_HQ]   = ctx_q[S_MUL3].q;
    mul_a[M_VQ]   = ctx_q[S_MUL3].v;   mul_b[M_VQ]   = ctx_q[S_MUL3].q;
    mul_a[M_GMQ]  = gm1_val;           mul_b[M_GMQ]  = ctx_q[S_GMQ].qv;
    mul_a[M_M1]   = ctx_q[S_MUL4].rho; mul_b[M_M1]   = ctx_q[S_MUL4].t1;
    mul_a[M_GVQ]  = gm1_val;           mul_b[M_GVQ]  = ctx_q[S_MUL4].vq;
    mul_a[M_HG]   = QHALF;             mul_b[M_HG]   = ctx_q[S_MUL4].gmq;
    mul_a[M_P]    = gm1_val;           mul_b[M_P]    = ctx_q[S_P].m1;
    mul_a[M_SJ10] = ctx_q[S_SJ].s;     mul_b[M_SJ10] = ctx_q[S_SJ].j10;
    mul_a[M_SJ11] = ctx_q[S_SJ].s;     mul_b[M_SJ11] = ctx_q[S_SJ].v;
    mul_a[M_SJ12] = ctx_q[S_SJ].s;     mul_b[M_SJ12] = ctx_q[S_SJ].u;
    mul_a[M_SJ20] = ctx_q[S_SJ].s;     mul_b[M_SJ20] = ctx_q[S_SJ].j20;
    mul_a[M_SJ22] = ctx_q[S_SJ].s;     mul_b[M_SJ22] = ctx_q[S_SJ].j22;
    mul_a[M_SJ30] = ctx_q[S_SJ].s;     mul_b[M_SJ30] = ctx_q[S_SJ].j30;
    mul_a[M_SJ31] = ctx_q[S_SJ].s;     mul_b[M_SJ31] = ctx_q[S_SJ].j31;
    mul_a[M_SJ32] = ctx_q[S_SJ].s;     mul_b[M_SJ32] = ctx_q[S_SJ].j32;
    mul_a[M_SJ33] = ctx_q[S_SJ].s;     mul_b[M_SJ33] = ctx_q[S_SJ].gv;
    mul_a[M_HMY]  = ctx_q[S_HMY].h;    mul_b[M_HMY]  = ctx_q[S_HMY].my;
    mul_a[M_RES3] = ctx_q[S_RES3].s;   mul_b[M_RES3] = ctx_q[S_RES3].hmy;
  end

  // ---------------------------------------------------------------------------
  // Stage contents: each stage copies the one before it and picks up the
  // results that become ready there.
  // ---------------------------------------------------------------------------
  always_comb begin
    ctx_d[0]         = '0;
    ctx_d[0].rho     = qval_t'({1'b0, in_word_i.density});
    ctx_d[0].mx      = in_word_i.momentum_x;
    ctx_d[0].my      = in_word_i.momentum_y;
    ctx_d[0].egy     = in_word_i.total_energy;
    ctx_d[0].rad     = in_word_i.radius;
    ctx_d[0].vol     = qval_t'({1'b0, in_word_i.cell_volume});
    // Cells whose radius is not above one LSB lie on or below the axis.
    ctx_d[0].axis_ok = (in_word_i.radius > 48'sd1);
    for (int i = 1; i < NUM_STAGES; i++) begin
      ctx_d[i] = ctx_q[i-1];
    end

    ctx_d[DD].s = div_q[D_S];
    ctx_d[DD].u = div_q[D_U];
    ctx_d[DD].v = div_q[D_V];
    ctx_d[DD].e = div_q[D_E];

    ctx_d[S_MUL1+DM].uu  = mul_p[M_UU];
    ctx_d[S_MUL1+DM].vv  = mul_p[M_VV];
    ctx_d[S_MUL1+DM].mxv = mul_p[M_MXV];
    ctx_d[S_MUL1+DM].myv = mul_p[M_MYV];
    ctx_d[S_MUL1+DM].uv  = mul_p[M_UV];
    ctx_d[S_MUL1+DM].ve  = mul_p[M_VE];
    ctx_d[S_MUL1+DM].ge  = mul_p[M_GE];
    ctx_d[S_MUL1+DM].gv  = mul_p[M_GV];
    ctx_d[S_MUL1+DM].smy = mul_p[M_SMY];

    // Squared speed, and the doubled v*v of the energy row.
    ctx_d[S_MUL2+1].q   = sat_add(ctx_q[S_MUL2].uu, ctx_q[S_MUL2].vv);
    ctx_d[S_MUL2+1].vv2 = sat_add(ctx_q[S_MUL2].vv, ctx_q[S_MUL2].vv);

    ctx_d[S_MUL2+DM].res1  = mul_p[M_RES1];
    ctx_d[S_MUL2+DM].res2  = mul_p[M_RES2];
    ctx_d[S_MUL2+DM].gm1uv = mul_p[M_GUV];
    ctx_d[S_MUL2+DM].gve   = mul_p[M_GVE];

    ctx_d[S_MUL3+1].qv = sat_add(ctx_q[S_MUL3].q, ctx_q[S_MUL3].vv2);

    ctx_d[S_MUL3+DM].hq = mul_p[M_HQ];
    ctx_d[S_MUL3+DM].vq = mul_p[M_VQ];
    ctx_d[S_GMQ+DM].gmq = mul_p[M_GMQ];

    // Internal energy per mass: e minus half the squared speed.
    ctx_d[S_T1+1].t1 = sat_sub(ctx_q[S_T1].e, ctx_q[S_T1].hq);

    ctx_d[S_MUL4+DM].m1  = mul_p[M_M1];
    ctx_d[S_MUL4+DM].gvq = mul_p[M_GVQ];
    ctx_d[S_MUL4+DM].hg  = mul_p[M_HG];

    ctx_d[S_P+1].j30 = sat_sub(ctx_q[S_P].gvq, ctx_q[S_P].gve);
    ctx_d[S_P+1].j31 = sat_neg(ctx_q[S_P].gm1uv);
    ctx_d[S_P+1].j32 = sat_sub(ctx_q[S_P].ge, ctx_q[S_P].hg);
    ctx_d[S_P+1].j10 = sat_neg(ctx_q[S_P].uv);
    ctx_d[S_P+1].j20 = sat_neg(ctx_q[S_P].vv);
    ctx_d[S_P+1].j22 = sat_add(ctx_q[S_P].v, ctx_q[S_P].v);

    ctx_d[S_P+DM].p = mul_p[M_P];

    ctx_d[S_SJ+DM].sj10 = mul_p[M_SJ10];
    ctx_d[S_SJ+DM].sj11 = mul_p[M_SJ11];
    ctx_d[S_SJ+DM].sj12 = mul_p[M_SJ12];
    ctx_d[S_SJ+DM].sj20 = mul_p[M_SJ20];
    ctx_d[S_SJ+DM].sj22 = mul_p[M_SJ22];
    ctx_d[S_SJ+DM].sj30 = mul_p[M_SJ30];
    ctx_d[S_SJ+DM].sj31 = mul_p[M_SJ31];
    ctx_d[S_SJ+DM].sj32 = mul_p[M_SJ32];
    ctx_d[S_SJ+DM].sj33 = mul_p[M_SJ33];

    // Total enthalpy numerator: energy plus pressure.
    ctx_d[S_EP+1].ep = sat_add(ctx_q[S_EP].egy, ctx_q[S_EP].p);

    ctx_d[S_DIVH+DD].h    = div_q[D_H];
    ctx_d[S_HMY+DM].hmy   = mul_p[M_HMY];
    ctx_d[S_RES3+DM].res3 = mul_p[M_RES3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NUM_STAGES; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        ctx_q[i] <= ctx_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row assembly. Cells on or below the axis give zero everywhere; explicit
  // mode zeroes the Jacobian. The mass row's only Jacobian entry is s times one.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic ax, jx;
    ax = ctx_q[S_LAST].axis_ok;
    jx = ax && implicit_q;
    res_row[0] = ax ? ctx_q[S_LAST].smy  : '0;
    res_row[1] = ax ? ctx_q[S_LAST].res1 : '0;
    res_row[2] = ax ? ctx_q[S_LAST].res2 : '0;
    res_row[3] = ax ? ctx_q[S_LAST].res3 : '0;
    for (int r = 0; r < EQUATION_ROWS; r++) begin
      for (int c = 0; c < EQUATION_ROWS; c++) begin
        jac_row[r][c] = '0;
      end
    end
    if (jx) begin
      jac_row[0][2] = ctx_q[S_LAST].s;
      jac_row[1][0] = ctx_q[S_LAST].sj10;
      jac_row[1][1] = ctx_q[S_LAST].sj11;
      jac_row[1][2] = ctx_q[S_LAST].sj12;
      jac_row[2][0] = ctx_q[S_LAST].sj20;
      jac_row[2][2] = ctx_q[S_LAST].sj22;
      jac_row[3][0] = ctx_q[S_LAST].sj30;
      jac_row[3][1] = ctx_q[S_LAST].sj31;
      jac_row[3][2] = ctx_q[S_LAST].sj32;
      jac_row[3][3] = ctx_q[S_LAST].sj33;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_vld_q <= 1'b0;
      row_q      <= '0;
    end else if (load) begin
      obuf_vld_q <= 1'b1;
      row_q      <= '0;
    end else if (out_acc) begin
      if (row_q == LAST_ROW) begin
        obuf_vld_q <= 1'b0;
        row_q      <= '0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int r = 0; r < EQUATION_ROWS; r++) begin
        res_buf_q[r] <= res_row[r];
        for (int c = 0; c < EQUATION_ROWS; c++) begin
          jac_buf_q[r][c] <= jac_row[r][c];
        end
      end
    end
  end

  assign out_valid_o               = obuf_vld_q;
  assign out_word_o.row_index      = row_q;
  assign out_word_o.residual_value = res_buf_q[row_q];
  assign out_word_o.jac_col0       = jac_buf_q[row_q][0];
  assign out_word_o.jac_col1       = jac_buf_q[row_q][1];
  assign out_word_o.jac_col2       = jac_buf_q[row_q][2];
  assign out_word_o.jac_col3       = jac_buf_q[row_q][3];
  assign out_word_o.last_row       = (row_q == LAST_ROW);

endmodule

>>> hw/rtl/acs_checker.sv
// Port-level checks of the axisymmetric source block, bound to its top level.
// Depends on acs_pkg and axisymmetric_compressible_source_defines.svh.
`include "axisymmetric_compressible_source_defines.svh"

module acs_checker import acs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // A stalled word holds.
  `ACS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))

  // Rows of a cell follow each other without gaps.
  `ACS_ASSERT_NEXT(a_row_seq, out_valid_o && out_ready_i && !out_word_o.last_row, out_valid_o && (out_word_o.row_index == $past(out_word_o.row_index) + 2'd1))

  // The last flag marks the energy row and nothing else.
  `ACS_ASSERT_SAME(a_last_flag, out_valid_o, out_word_o.last_row == (out_word_o.row_index == LAST_ROW))

  // The mass row depends on the radial momentum only.
  `ACS_ASSERT_SAME(a_mass_row, out_valid_o && out_word_o.row_index == 2'd0, out_word_o.jac_col0 == '0 && out_word_o.jac_col1 == '0 && out_word_o.jac_col3 == '0)

endmodule

bind axisymmetric_compressible_source acs_checker u_acs_checker (.*);

>>> test/axisymmetric_compressible_source_tb.sv
// Self-checking testbench of the axisymmetric compressible source block.
// Depends on acs_pkg and the axisymmetric_compressible_source top level.
`timescale 1ns / 1ps

module axisymmetric_compressible_source_tb;
  import acs_pkg::*;

  // The first row leaves the block after its cell has passed every stage.
  localparam int DRAIN_CYCLES  = 160;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_word_t             in_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_word_t            out_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GAMMA_W-1:0]   cfg_data_i;

  axisymmetric_compressible_source uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Our own copy of the two registers, updated on every accepted write.
  logic [GAMMA_W-1:0] gamma_copy;
  logic               implicit_copy;

  // Rows that the block still owes us, oldest first.
  out_word_t pending_rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  // When set, neither side inserts gaps. hold_request asks the receiver for
  // one long stall; the receiver clears it once the stall is over.
  bit no_gaps;
  bit hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor. Values are carried in 64 bits and saturated to
  // the 48-bit Q16.32 range after each operation, as the block does.
  // ---------------------------------------------------------------------
  typedef logic signed [63:0] wide_t;

  localparam wide_t W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam wide_t W_MIN = -64'sh0000_8000_0000_0000;
  localparam wide_t W_ONE = 64'sh0000_0001_0000_0000;
  localparam wide_t W_HALF = 64'sh0000_0000_8000_0000;

  function automatic wide_t clamp(input wide_t x);
    if (x > W_MAX) return W_MAX;
    if (x < W_MIN) return W_MIN;
    return x;
  endfunction

  function automatic wide_t q_add(input wide_t a, input wide_t b);
    return clamp(a + b);
  endfunction

  function automatic wide_t q_sub(input wide_t a, input wide_t b);
    return clamp(a - b);
  endfunction

  // Applies a sign to a magnitude, saturating at both ends of the range.
  function automatic wide_t signed_mag(input logic [127:0] m, input bit neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000) return W_MIN;
      return -wide_t'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return W_MAX;
    return wide_t'(m[63:0]);
  endfunction

  // Product rounded to nearest, ties away from zero, on the magnitudes.
  function automatic wide_t q_mul(input wide_t a, input wide_t b);
    logic [127:0] ma, mb, m;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    m  = (ma * mb + 128'h8000_0000) >> 32;
    return signed_mag(m, (a < 0) != (b < 0));
  endfunction

  // Quotient a*2^32/b rounded the same way; a zero divisor saturates by the
  // sign of the numerator.
  function automatic wide_t q_div(input wide_t a, input wide_t b);
    logic [127:0] ma, mb, q, r;
    if (b == 0) return (a < 0) ? W_MIN : W_MAX;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    q  = (ma << 32) / mb;
    r  = (ma << 32) % mb;
    if ((r << 1) >= mb) q = q + 1;
    return signed_mag(q, (a < 0) != (b < 0));
  endfunction

  // Works out the four rows of one cell under the current register copy.
  task automatic push_source_rows(input in_word_t c);
    wide_t rho, mx, my, en, rad, vol, g, gm1, s, u, v, q, e, p, h, uv, vv;
    wide_t res[4];
    wide_t jac[4][4];
    out_word_t w;
    rho = wide_t'({17'd0, c.density});
    mx  = wide_t'(c.momentum_x);
    my  = wide_t'(c.momentum_y);
    en  = wide_t'(c.total_energy);
    rad = wide_t'(c.radius);
    vol = wide_t'({17'd0, c.cell_volume});
    for (int i = 0; i < 4; i++) begin
      res[i] = 0;
      for (int j = 0; j < 4; j++) jac[i][j] = 0;
    end
    // On or below the axis everything stays zero.
    if (rad > 1) begin
      g   = wide_t'({30'd0, gamma_copy});
      gm1 = q_sub(g, W_ONE);
      s   = q_div(vol, rad);
      u   = q_div(mx, rho);
      v   = q_div(my, rho);
      q   = q_add(q_mul(u, u), q_mul(v, v));
      e   = q_div(en, rho);
      p   = q_mul(gm1, q_mul(rho, q_sub(e, q_mul(W_HALF, q))));
      h   = q_div(q_add(en, p), rho);
      res[0] = q_mul(s, my);
      res[1] = q_mul(s, q_mul(mx, v));
      res[2] = q_mul(s, q_mul(my, v));
      res[3] = q_mul(s, q_mul(h, my));
      if (implicit_copy) begin
        uv = q_mul(u, v);
        vv = q_mul(v, v);
        jac[0][2] = W_ONE;
        jac[1][0] = q_sub(0, uv);
        jac[1][1] = v;
        jac[1][2] = u;
        jac[2][0] = q_sub(0, vv);
        jac[2][2] = q_add(v, v);
        jac[3][0] = q_sub(q_mul(gm1, q_mul(v, q)), q_mul(g, q_mul(v, e)));
        jac[3][1] = q_sub(0, q_mul(gm1, uv));
        // The half here is a true 0.5, not an integer division.
        jac[3][2] = q_sub(q_mul(g, e),
                          q_mul(W_HALF, q_mul(gm1, q_add(q, q_add(vv, vv)))));
        jac[3][3] = q_mul(g, v);
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) jac[i][j] = q_mul(s, jac[i][j]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      w.row_index      = ROW_W'(i);
      w.residual_value = qval_t'(res[i]);
      w.jac_col0       = qval_t'(jac[i][0]);
      w.jac_col1       = qval_t'(jac[i][1]);
      w.jac_col2       = qval_t'(jac[i][2]);
      w.jac_col3       = qval_t'(jac[i][3]);
      w.last_row       = (ROW_W'(i) == LAST_ROW);
      pending_rows.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one cell word and waits until it is taken. Valid stays high into
  // the next word when no gap follows.
  task automatic send_cell(input in_word_t c);
    int gap;
    in_valid_i <= 1'b1;
    in_word_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    push_source_rows(c);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every owed row has come and the pipeline has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [GAMMA_W-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_GAMMA) gamma_copy = data;
    else if (idx == REG_IMPLICIT) implicit_copy = data[0];
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus sources.
  // ---------------------------------------------------------------------

  function automatic qval_t q_of(input int whole);
    return qval_t'(longint'(whole) <<< 32);
  endfunction

  function automatic qval_t rand_q48();
    return qval_t'({$urandom, $urandom});
  endfunction

  // Signed value of moderate size, roughly -span to +span.
  function automatic qval_t rand_moderate(input int span);
    longint m;
    m = (longint'($urandom_range(0, 2 * span - 1)) << 32) | longint'($urandom);
    return qval_t'(m - (longint'(span) << 32));
  endfunction

  function automatic logic [46:0] rand_positive(input int span);
    return 47'((longint'($urandom_range(0, span - 1)) << 32) | longint'($urandom));
  endfunction

  // Most cells look like a physical state off the axis; the rest are raw
  // bit patterns, zero densities and cells on or below the axis.
  function automatic in_word_t rand_cell();
    in_word_t c;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      c.density      = rand_positive(8) | 47'h1000_0000;
      c.momentum_x   = rand_moderate(8);
      c.momentum_y   = rand_moderate(8);
      c.total_energy = rand_moderate(32);
      c.radius       = qval_t'(rand_positive(16)) + qval_t'(2);
      c.cell_volume  = rand_positive(4);
    end else begin
      c.density      = 47'(rand_q48());
      c.momentum_x   = rand_q48();
      c.momentum_y   = rand_q48();
      c.total_energy = rand_q48();
      c.radius       = rand_q48();
      c.cell_volume  = 47'(rand_q48());
      if (kind < 78) c.density = '0;
      else if (kind < 84) c.radius = qval_t'($urandom_range(0, 1));
    end
    return c;
  endfunction

  function automatic logic [GAMMA_W-1:0] rand_gamma();
    return GAMMA_W'((64'd1 << 32) + (64'($urandom_range(0, 1)) << 32) + 64'($urandom));
  endfunction

  function automatic in_word_t plain_cell();
    in_word_t c;
    c.density      = 47'(q_of(1));
    c.momentum_x   = q_of(1);
    c.momentum_y   = q_of(-2);
    c.total_energy = q_of(5);
    c.radius       = q_of(3);
    c.cell_volume  = 47'(q_of(2));
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------

  // Two ordinary cells under the reset values of both registers.
  task automatic test_reset_defaults();
    in_word_t c;
    c = plain_cell();
    send_cell(c);
    c.momentum_x = q_of(-3);
    c.momentum_y = q_of(4);
    send_cell(c);
  endtask

  // Cells on the axis, just off it, below it, and with zero density.
  task automatic test_axis_and_zero_density();
    in_word_t c;
    c = plain_cell();
    c.radius = '0;
    send_cell(c);
    c.radius = qval_t'(1);
    send_cell(c);
    c.radius = qval_t'(2);
    send_cell(c);
    c.radius = q_of(-4);
    send_cell(c);
    c = plain_cell();
    c.density = '0;
    send_cell(c);
    c.total_energy = q_of(-5);
    c.momentum_y = q_of(-1);
    send_cell(c);
    c.momentum_x = '0;
    c.momentum_y = '0;
    c.total_energy = '0;
    send_cell(c);
  endtask

  // Largest and smallest field values, which push the arithmetic into
  // saturation, then a tiny density and radius and a cell below the axis.
  task automatic test_field_extremes();
    in_word_t c;
    c.density      = '1;
    c.momentum_x   = QMAX;
    c.momentum_y   = QMAX;
    c.total_energy = QMAX;
    c.radius       = QMAX;
    c.cell_volume  = '1;
    send_cell(c);
    c.momentum_x   = QMIN;
    c.momentum_y   = QMIN;
    c.total_energy = QMIN;
    send_cell(c);
    c.density      = 47'd1;
    c.radius       = qval_t'(2);
    send_cell(c);
    c.cell_volume  = '0;
    c.radius       = QMIN;
    send_cell(c);
  endtask

  // Explicit mode must zero all Jacobian columns.
  task automatic test_explicit_mode();
    in_word_t c;
    write_reg(REG_IMPLICIT, '0);
    c = plain_cell();
    send_cell(c);
    c.radius = '0;
    send_cell(c);
    write_reg(REG_IMPLICIT, GAMMA_W'(1));
  endtask

  // Gamma at one, at three, below one and at its largest value, and two ignored
  // writes to indexes that hold no register.
  task automatic test_gamma_settings();
    write_reg(REG_GAMMA, GAMMA_W'(64'd1 << 32));
    send_cell(plain_cell());
    write_reg(REG_GAMMA, GAMMA_W'(64'd3 << 32));
    send_cell(plain_cell());
    write_reg(REG_GAMMA, GAMMA_W'(64'd1 << 31));
    send_cell(plain_cell());
    write_reg(REG_GAMMA, '1);
    send_cell(plain_cell());
    write_reg(REG_UNUSED, GAMMA_W'(64'd2 << 32));
    send_cell(plain_cell());
    write_reg(~REG_UNUSED, '0);
    send_cell(plain_cell());
  endtask

  // The receiver stalls for a long stretch while cells keep coming. The
  // pipeline holds 132 cells plus one in the output buffer, so more cells
  // than that are offered and the input stalls; then the sender waits for
  // all rows.
  task automatic test_backpressure();
    drain();
    no_gaps = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 145; i++) send_cell(rand_cell());
    no_gaps = 1'b0;
    drain();
  endtask

  // Random cells under several register settings, the extremes among them.
  task automatic test_random_sweep();
    logic [GAMMA_W-1:0] gammas[5];
    gammas[0] = GAMMA_W'(64'd1 << 32);
    gammas[1] = GAMMA_W'(64'd3 << 32);
    gammas[2] = rand_gamma();
    gammas[3] = rand_gamma();
    gammas[4] = GAMMA_RESET;
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_GAMMA, gammas[k]);
      write_reg(REG_IMPLICIT, GAMMA_W'(k != 2));
      // Only the stretch of the fourth setting runs without any gaps.
      no_gaps = (k == 3);
      for (int i = 0; i < 22; i++) send_cell(rand_cell());
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ready_i <= (stall == 0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted row against the oldest owed row.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row word: %h", out_word_o);
      end else begin
        want = pending_rows.pop_front();
        if (out_word_o.row_index !== want.row_index ||
            out_word_o.residual_value !== want.residual_value ||
            out_word_o.jac_col0 !== want.jac_col0 ||
            out_word_o.jac_col1 !== want.jac_col1 ||
            out_word_o.jac_col2 !== want.jac_col2 ||
            out_word_o.jac_col3 !== want.jac_col3 ||
            out_word_o.last_row !== want.last_row) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("row mismatch: expected row %0d res %h jac %h %h %h %h last %b",
                     want.row_index, want.residual_value, want.jac_col0,
                     want.jac_col1, want.jac_col2, want.jac_col3, want.last_row);
            $display("              actual   row %0d res %h jac %h %h %h %h last %b",
                     out_word_o.row_index, out_word_o.residual_value,
                     out_word_o.jac_col0, out_word_o.jac_col1,
                     out_word_o.jac_col2, out_word_o.jac_col3,
                     out_word_o.last_row);
          end
        end
      end
    end
  end

  // Watchdog: ends a run in which no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------
  initial begin
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    gamma_copy    = GAMMA_RESET;
    implicit_copy = 1'b1;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_axis_and_zero_density();
    test_field_extremes();
    test_explicit_mode();
    test_gamma_settings();
    test_backpressure();
    test_random_sweep();
    drain();

    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
